### hw/rtl/hpl_pkg.sv
package hpl_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_MU_SCALE   = 2'd1;
    localparam logic [1:0] CFG_INV_TEMP   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [24:0] NODE_COUNT_RST = 25'd1024;
    localparam logic [31:0] MU_SCALE_RST   = 32'd8388608;
    localparam logic [31:0] INV_TEMP_RST   = 32'd33554432;

    // Fraction bits of the log and exponent formats
    localparam int FRAC_BITS = 24;

    // Integer square root, used only to build constants at elaboration
    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x   = v;
        res = 64'd0;
        b   = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (x >= res + b) begin
                    x   = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // Root k of the chain c_k = isqrt(c_(k-1) * 2^30), c_0 = 2^31, in Q1.30
    function automatic logic [31:0] f_root(input int k);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int j = 1; j <= FRAC_BITS; j++) begin
            if (j <= k) begin
                c = f_isqrt(c << 30);
            end
        end
        return c[31:0];
    endfunction

endpackage

### hw/rtl/hpl_log2.sv
// Pipelined log2 in Q.24: leading-one search over two stages, normalize,
// then one squaring step per stage.
module hpl_log2 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_value,
    output logic [29:0] o_log
);

    localparam int NSQ = hpl_pkg::FRAC_BITS;

    logic [63:0] r_a_val;
    logic [3:0]  r_a_any;
    logic [3:0]  r_a_pos [0:3];
    logic [63:0] r_b_val;
    logic [5:0]  r_b_p;
    logic [31:0] r_m  [0:NSQ];
    logic [23:0] r_fr [0:NSQ];
    logic [5:0]  r_p  [0:NSQ];

    logic [3:0]  n_any;
    logic [3:0]  n_pos [0:3];
    logic [5:0]  n_p;
    logic [63:0] n_norm;

    // Find the top set bit inside each 16-bit group
    always_comb begin
        for (int g = 0; g < 4; g++) begin
            n_any[g] = |i_value[g*16 +: 16];
            n_pos[g] = 4'd0;
            for (int b = 0; b < 16; b++) begin
                if (i_value[g*16 + b]) begin
                    n_pos[g] = 4'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_val <= i_value;
            r_a_any <= n_any;
            for (int g = 0; g < 4; g++) begin
                r_a_pos[g] <= n_pos[g];
            end
        end
    end

    // Pick the highest nonempty group
    always_comb begin
        if (r_a_any[3]) begin
            n_p = {2'd3, r_a_pos[3]};
        end else if (r_a_any[2]) begin
            n_p = {2'd2, r_a_pos[2]};
        end else if (r_a_any[1]) begin
            n_p = {2'd1, r_a_pos[1]};
        end else begin
            n_p = {2'd0, r_a_pos[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_val <= r_a_val;
            r_b_p   <= n_p;
        end
    end

    // Normalize to Q1.31
    always_comb begin
        if (r_b_p >= 6'd31) begin
            n_norm = r_b_val >> (r_b_p - 6'd31);
        end else begin
            n_norm = r_b_val << (6'd31 - r_b_p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]  <= n_norm[31:0];
            r_fr[0] <= 24'd0;
            r_p[0]  <= r_b_p;
        end
    end

    // Square and take one fraction bit per stage
    for (genvar k = 1; k <= NSQ; k++) begin : g_sq
        logic [63:0] sq;
        logic [32:0] s;
        always_comb begin
            sq = 64'(r_m[k-1]) * 64'(r_m[k-1]);
            s  = sq[63:31];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[k]  <= s[32] ? s[32:1] : s[31:0];
                r_fr[k] <= {r_fr[k-1][22:0], s[32]};
                r_p[k]  <= r_p[k-1];
            end
        end
    end

    assign o_log = {r_p[NSQ], r_fr[NSQ]};

endmodule

### hw/rtl/hpl_div.sv
// Pipelined restoring divider for floor(2^62 / d), d >= 2^30.
// One quotient bit per stage, 33 stages.
module hpl_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_divisor,
    output logic [32:0] o_quot
);

    localparam int NQ = 33;

    logic [63:0] r_rem [0:NQ-1];
    logic [63:0] r_dv  [0:NQ-1];
    logic [32:0] r_q   [0:NQ-1];

    for (genvar j = 0; j < NQ; j++) begin : g_step
        logic [63:0] rem_in;
        logic [63:0] dv_in;
        logic [32:0] q_in;
        logic [64:0] r2;
        logic        ge;
        logic [64:0] diff;
        // First stage starts from the top of the dividend
        if (j == 0) begin : g_head
            assign rem_in = 64'd1 << 29;
            assign dv_in  = i_divisor;
            assign q_in   = 33'd0;
        end else begin : g_tail
            assign rem_in = r_rem[j-1];
            assign dv_in  = r_dv[j-1];
            assign q_in   = r_q[j-1];
        end
        always_comb begin
            r2   = {rem_in, 1'b0};
            ge   = r2 >= {1'b0, dv_in};
            diff = r2 - {1'b0, dv_in};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? diff[63:0] : r2[63:0];
                r_dv[j]  <= dv_in;
                r_q[j]   <= {q_in[31:0], ge};
            end
        end
    end

    assign o_quot = r_q[NQ-1];

endmodule

### hw/rtl/hyperbolic_pair_link_decision.sv
// Channel   Dir  Width  Contents
// s_axis    in   208    index_a, index_b, angle_a, angle_b, degree_a, degree_b, random_draw
// m_axis    out  88     pair_a, pair_b, link, probability
// cfg       in   2+32   node_count, mu_scale, inv_temperature
//
// One item per cycle while the output queue has room; the path from input to the
// output queue runs through the 24 squaring stages of the log units, the 24
// multiply stages of the exponent and the 33-bit one-bit-per-stage divider.
// Reset clears the valid bits and the output queue and loads the configuration defaults.
// The whole pipeline advances while the two-entry output queue has room,
// so one finished result may wait without blocking the input.
module hyperbolic_pair_link_decision #(
    parameter int INDEX_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // index_a[23:0], index_b[47:24], angle_a[79:48], angle_b[111:80],
    // degree_a[143:112], degree_b[175:144], random_draw[207:176]
    input  logic [207:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // pair_a[23:0], pair_b[47:24], link[48], probability[81:49], zero[87:82]
    output logic [87:0]  o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);

    localparam int KEEP     = (INDEX_BITS < 24) ? INDEX_BITS : 24;
    localparam int LOG_LAT  = 27;
    localparam int POST_LAT = 4;
    localparam int EXP_LAT  = hpl_pkg::FRAC_BITS;
    localparam int DIV_LAT  = 33;
    localparam int SIDE_LAT = LOG_LAT + POST_LAT + EXP_LAT + 1 + DIV_LAT;

    typedef struct packed {
        logic [KEEP-1:0] ia;
        logic [KEEP-1:0] ib;
        logic [31:0]     draw;
        logic            zero;
        logic            one;
    } t_side;

    typedef struct packed {
        logic [15:0] sh;
        logic        neg;
        logic        big;
    } t_shift;

    // Configuration
    logic [24:0] r_node_count;
    logic [31:0] r_mu;
    logic [31:0] r_inv_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= hpl_pkg::NODE_COUNT_RST;
            r_mu         <= hpl_pkg::MU_SCALE_RST;
            r_inv_t      <= hpl_pkg::INV_TEMP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hpl_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data[24:0];
                hpl_pkg::CFG_MU_SCALE:   r_mu         <= i_cfg_data;
                hpl_pkg::CFG_INV_TEMP:   r_inv_t      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline enable and output queue state
    logic        en;
    logic        pop;
    logic        push;
    logic [1:0]  r_cnt;
    logic        r_wr;
    logic        r_rd;
    logic [87:0] r_fifo [0:1];

    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign en              = (r_cnt != 2'd2) || pop;
    assign o_s_axis_tready = en;

    // Stage 1: wrapped angular distance
    logic [31:0] n_diff;
    logic [32:0] n_wrap;
    logic [31:0] n_dist;

    always_comb begin
        n_diff = i_s_axis_tdata[79:48] - i_s_axis_tdata[111:80];
        n_wrap = 33'h1_0000_0000 - {1'b0, n_diff};
        n_dist = (n_diff > 32'h8000_0000) ? n_wrap[31:0] : n_diff;
    end

    logic            r_s1_vld;
    logic [31:0]     r_s1_dist;
    logic [31:0]     r_s1_ka;
    logic [31:0]     r_s1_kb;
    logic [KEEP-1:0] r_s1_ia;
    logic [KEEP-1:0] r_s1_ib;
    logic [31:0]     r_s1_draw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_dist <= n_dist;
            r_s1_ka   <= i_s_axis_tdata[143:112];
            r_s1_kb   <= i_s_axis_tdata[175:144];
            r_s1_ia   <= i_s_axis_tdata[KEEP-1:0];
            r_s1_ib   <= i_s_axis_tdata[24 +: KEEP];
            r_s1_draw <= i_s_axis_tdata[207:176];
        end
    end

    // Stage 2: scaled distance, degree product, special-case flags
    logic        r_s2_vld;
    logic [63:0] r_s2_num;
    logic [63:0] r_s2_kp;
    t_side       r_s2_side;
    logic [56:0] n_num;

    assign n_num = 57'(r_node_count) * 57'(r_s1_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_num       <= {7'd0, n_num};
            r_s2_kp        <= 64'(r_s1_ka) * 64'(r_s1_kb);
            r_s2_side.ia   <= r_s1_ia;
            r_s2_side.ib   <= r_s1_ib;
            r_s2_side.draw <= r_s1_draw;
            r_s2_side.zero <= (r_s1_ka == 32'd0) || (r_s1_kb == 32'd0) || (r_mu == 32'd0);
            r_s2_side.one  <= (r_node_count == 25'd0) || (r_s1_dist == 32'd0);
        end
    end

    // Delay line for side data and valid bits
    logic  r_vld  [1:SIDE_LAT];
    t_side r_side [1:SIDE_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= SIDE_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[1] <= r_s2_vld;
            for (int i = 2; i <= SIDE_LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[1] <= r_s2_side;
            for (int i = 2; i <= SIDE_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Three log units
    logic [29:0] lg_num;
    logic [29:0] lg_kp;
    logic [29:0] lg_mu;

    hpl_log2 u_log_num (.i_clk(i_clk), .i_en(en), .i_value(r_s2_num), .o_log(lg_num));
    hpl_log2 u_log_kp  (.i_clk(i_clk), .i_en(en), .i_value(r_s2_kp),  .o_log(lg_kp));
    hpl_log2 u_log_mu  (.i_clk(i_clk), .i_en(en), .i_value({32'd0, r_mu}), .o_log(lg_mu));

    // Post stages: log of x, magnitude, exponent scaling, split
    logic [32:0] r_e1_l;
    logic        r_e2_neg;
    logic [30:0] r_e2_mag;
    logic        r_e3_neg;
    logic [38:0] r_e3_ymag;
    logic [23:0] r_e4_f;
    t_shift      r_e4_sh;

    logic [32:0] n_l;
    logic [32:0] n_negl;
    logic [62:0] n_prod;
    logic [14:0] n_whole;
    logic [23:0] n_f0;
    logic [23:0] n_f;
    t_shift      n_sh;

    always_comb begin
        n_l = 33'(lg_num) + (33'd24 << hpl_pkg::FRAC_BITS) - 33'(lg_kp) - 33'(lg_mu);
        n_negl = 33'd0 - r_e1_l;
        n_prod = 63'(r_e2_mag) * 63'(r_inv_t);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1_l    <= n_l;
            r_e2_neg  <= r_e1_l[32];
            r_e2_mag  <= r_e1_l[32] ? n_negl[30:0] : r_e1_l[30:0];
            r_e3_neg  <= r_e2_neg;
            r_e3_ymag <= n_prod[62:24];
        end
    end

    // Split into whole shift and fraction; fold negative fractions
    always_comb begin
        n_whole  = r_e3_ymag[38:24];
        n_f0     = r_e3_ymag[23:0];
        n_sh.neg = r_e3_neg;
        n_sh.big = !r_e3_neg && (n_whole > 15'd32);
        if (r_e3_neg && (n_f0 != 24'd0)) begin
            n_sh.sh = 16'(n_whole) + 16'd1;
            n_f     = (~n_f0) + 24'd1;
        end else begin
            n_sh.sh = 16'(n_whole);
            n_f     = r_e3_neg ? 24'd0 : n_f0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e4_f  <= n_f;
            r_e4_sh <= n_sh;
        end
    end

    // Exponent: one conditional root multiply per stage
    logic [31:0] r_acc [1:EXP_LAT];
    logic [23:0] r_xf  [1:EXP_LAT];
    t_shift      r_xsh [1:EXP_LAT];

    for (genvar k = 1; k <= EXP_LAT; k++) begin : g_exp
        localparam logic [31:0] ROOT = hpl_pkg::f_root(k);
        logic [31:0] acc_in;
        logic [23:0] f_in;
        t_shift      sh_in;
        logic [63:0] prod;
        // First stage starts from one
        if (k == 1) begin : g_head
            assign acc_in = 32'd1 << 30;
            assign f_in   = r_e4_f;
            assign sh_in  = r_e4_sh;
        end else begin : g_tail
            assign acc_in = r_acc[k-1];
            assign f_in   = r_xf[k-1];
            assign sh_in  = r_xsh[k-1];
        end
        always_comb begin
            prod = 64'(acc_in) * 64'(ROOT);
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_acc[k] <= f_in[EXP_LAT-k] ? prod[61:30] : acc_in;
                r_xf[k]  <= f_in;
                r_xsh[k] <= sh_in;
            end
        end
    end

    // Scale by the whole part and form the divisor
    logic [63:0] r_dvsr;
    logic        r_big [0:DIV_LAT];
    logic [63:0] n_t;
    t_shift      x_sh;

    always_comb begin
        x_sh = r_xsh[EXP_LAT];
        if (x_sh.neg) begin
            n_t = (x_sh.sh > 16'd63) ? 64'd0 : ({32'd0, r_acc[EXP_LAT]} >> x_sh.sh[5:0]);
        end else begin
            n_t = {32'd0, r_acc[EXP_LAT]} << x_sh.sh[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dvsr   <= (64'd1 << 30) + n_t;
            r_big[0] <= x_sh.big;
            for (int i = 1; i <= DIV_LAT; i++) begin
                r_big[i] <= r_big[i-1];
            end
        end
    end

    logic [32:0] quot;

    hpl_div u_div (.i_clk(i_clk), .i_en(en), .i_divisor(r_dvsr), .o_quot(quot));

    // Final selection
    t_side       last;
    logic [32:0] n_prob;
    logic        n_link;
    logic [87:0] n_word;

    always_comb begin
        last = r_side[SIDE_LAT];
        if (last.zero) begin
            n_prob = 33'd0;
        end else if (last.one) begin
            n_prob = 33'h1_0000_0000;
        end else if (r_big[DIV_LAT]) begin
            n_prob = 33'd0;
        end else begin
            n_prob = quot;
        end
        n_link = {1'b0, last.draw} < n_prob;
        n_word = {6'd0, n_prob, n_link, 24'(last.ib), 24'(last.ia)};
    end

    assign push = en && r_vld[SIDE_LAT];

    // Output queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr] <= n_word;
        end
    end

    assign o_m_axis_tvalid = r_cnt != 2'd0;
    assign o_m_axis_tdata  = r_fifo[r_rd];

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("output queue overflow");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_s1_vld)
        else $error("accepted item lost at first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> r_vld[SIDE_LAT] == $past(r_vld[SIDE_LAT]))
        else $error("pipeline moved during stall");

    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[81:49] <= 33'h1_0000_0000)
        else $error("probability above one");

    a_link_prob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[48] |-> o_m_axis_tdata[81:49] != 33'd0)
        else $error("link with zero probability");

endmodule

### test/hyperbolic_pair_link_decision_tb.sv
module hyperbolic_pair_link_decision_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_CYCLES = 100;
    localparam logic [1:0] CFG_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [31:0] draw;
        logic [31:0] deg_b;
        logic [31:0] deg_a;
        logic [31:0] ang_b;
        logic [31:0] ang_a;
        logic [23:0] idx_b;
        logic [23:0] idx_a;
    } t_pair_item;

    typedef struct packed {
        logic [5:0]  pad;
        logic [32:0] prob;
        logic        link;
        logic [23:0] pb;
        logic [23:0] pa;
    } t_link_item;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [207:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [87:0]  o_m_axis_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [31:0]  i_cfg_data;

    hyperbolic_pair_link_decision dut (.*);

    // Predictor copy of the registers
    logic [24:0] nodes_q;
    logic [31:0] mu_q;
    logic [31:0] invt_q;

    t_link_item expected_links[$];
    int         errors;
    bit         hold_off;
    int         hold_len;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("hyperbolic_pair_link_decision verification failed");
        $finish;
    end

    function automatic logic [63:0] isqrt_u64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint log2_fix(input logic [63:0] v);
        int p;
        logic [63:0] m;
        logic [63:0] frac;
        p = 63;
        frac = 0;
        while (v[p] == 1'b0 && p > 0) p--;
        m = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return longint'((64'(p) << 24) | frac);
    endfunction

    function automatic logic [63:0] pow2_frac(input logic [63:0] f);
        logic [63:0] acc;
        logic [63:0] root;
        acc = 64'd1 << 30;
        root = 64'd1 << 31;
        for (int k = 1; k <= 24; k++) begin
            root = isqrt_u64(root << 30);
            if (f[24-k]) acc = (acc * root) >> 30;
        end
        return acc;
    endfunction

    function automatic t_link_item predict_link(input t_pair_item it);
        t_link_item r;
        logic [63:0] diff, ang_gap, num, kp, prob, mag, ymag, whole, f0, f, t, sh;
        longint lv;
        r = '0;
        r.pa = it.idx_a;
        r.pb = it.idx_b;
        diff = (64'(it.ang_a) - 64'(it.ang_b)) & 64'hFFFF_FFFF;
        ang_gap = (diff > (64'd1 << 31)) ? (64'd1 << 32) - diff : diff;
        num = 64'(nodes_q) * ang_gap;
        kp = 64'(it.deg_a) * 64'(it.deg_b);
        if (kp == 0 || mu_q == 0) begin
            prob = 0;
        end else if (num == 0) begin
            prob = 64'd1 << 32;
        end else begin
            lv = log2_fix(num) + 24 * (longint'(1) << 24) - log2_fix(kp) - log2_fix(64'(mu_q));
            mag = (lv < 0) ? 64'(-lv) : 64'(lv);
            ymag = (mag * 64'(invt_q)) >> 24;
            whole = ymag >> 24;
            f0 = ymag & 64'hFFFFFF;
            if (lv >= 0) begin
                if (whole > 32) t = 64'hFFFF_FFFF_FFFF_FFFF;
                else t = pow2_frac(f0) << whole;
            end else begin
                if (f0 != 0) begin
                    sh = whole + 1;
                    f = (64'd1 << 24) - f0;
                end else begin
                    sh = whole;
                    f = 0;
                end
                t = (sh > 63) ? 0 : (pow2_frac(f) >> sh);
            end
            if (lv >= 0 && whole > 32) prob = 0;
            else prob = (64'd1 << 62) / ((64'd1 << 30) + t);
        end
        r.link = (64'(it.draw) < prob);
        r.prob = prob[32:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    // Receiver: random stalls, mostly short and a few long, plus one long hold-off
    initial begin
        int stall;
        stall = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                stall--;
            end else if ($urandom_range(0, 9) < 7) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                        $urandom_range(0, 2);
            end
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (hold_len > 0);
        hold_off = 1'b1;
        repeat (hold_len) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_link_item got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (expected_links.size() == 0) begin
                report_mismatch("unexpected item", 64'(got), 0);
            end else begin
                want = expected_links.pop_front();
                if (got.pa !== want.pa) report_mismatch("pair_a", got.pa, want.pa);
                if (got.pb !== want.pb) report_mismatch("pair_b", got.pb, want.pb);
                if (got.link !== want.link) report_mismatch("link", got.link, want.link);
                if (got.prob !== want.prob) report_mismatch("probability", got.prob, want.prob);
                if (got.pad !== '0) report_mismatch("pad", got.pad, 0);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            hpl_pkg::CFG_NODE_COUNT: nodes_q = val[24:0];
            hpl_pkg::CFG_MU_SCALE:   mu_q = val;
            hpl_pkg::CFG_INV_TEMP:   invt_q = val;
            default: ;
        endcase
    endtask

    // Wait until all expectations are drained, then let the pipe empty
    task automatic drain_links();
        while (expected_links.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
    endtask

    // Offer one item, with a random gap before it
    task automatic send_pair(input t_pair_item it, input logic check_typed,
                             input t_link_item typed);
        int gap;
        t_link_item p;
        gap = ($urandom_range(0, 9) < 7) ? 0 :
              (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= it;
        p = predict_link(it);
        if (check_typed && (p !== typed)) report_mismatch("table row", 64'(p.prob), 64'(typed.prob));
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_links.insert(expected_links.size(), check_typed ? typed : p);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'(1) << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_pair_item rand_pair();
        t_pair_item it;
        it.idx_a = 24'($urandom);
        it.idx_b = 24'($urandom);
        it.ang_a = $urandom;
        // Mostly nearby angles so the probability lands inside (0,1)
        it.ang_b = ($urandom_range(0, 3) == 0) ? $urandom :
                   it.ang_a + ($urandom >> $urandom_range(8, 31));
        if ($urandom_range(0, 15) == 0) it.ang_b = it.ang_a;
        it.deg_a = ($urandom_range(0, 15) == 0) ? rand_word() : $urandom_range(32'h1_0000, 32'h40_0000);
        it.deg_b = ($urandom_range(0, 15) == 0) ? rand_word() : $urandom_range(32'h1_0000, 32'h40_0000);
        it.draw = $urandom;
        return it;
    endfunction

    typedef struct {
        t_pair_item  it;
        logic        typed;
        t_link_item  res;
    } t_stim_row;

    initial begin
        t_stim_row rows[$];
        t_stim_row row;
        t_pair_item it;
        errors = 0;
        hold_len = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = hpl_pkg::CFG_NODE_COUNT;
        i_cfg_data = '0;
        nodes_q = hpl_pkg::NODE_COUNT_RST;
        mu_q = hpl_pkg::MU_SCALE_RST;
        invt_q = hpl_pkg::INV_TEMP_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: zero degree, zero distance, extremes
        row.it = '{32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h1234, 24'h0, 24'hFFFFFF};
        row.typed = 1'b1; row.res = '{6'd0, 33'd0, 1'b0, 24'h0, 24'hFFFFFF};
        rows.insert(rows.size(), row);
        row.it = '{32'hFFFF_FFFF, 32'h1_0000, 32'h1_0000, 32'h8000, 32'h8000, 24'hFFFFFF, 24'h0};
        row.typed = 1'b1; row.res = '{6'd0, 33'h1_0000_0000, 1'b1, 24'hFFFFFF, 24'h0};
        rows.insert(rows.size(), row);
        row.it = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 24'h1, 24'h2};
        row.typed = 1'b0; rows.insert(rows.size(), row);
        row.it = '{32'h0, 32'h1, 32'h1, 32'h8000_0000, 32'h0, 24'h3, 24'h4};
        rows.insert(rows.size(), row);
        row.it = '{32'h0, 32'h1, 32'h1, 32'h0, 32'h1, 24'h5, 24'h6};
        rows.insert(rows.size(), row);
        row.it = '{32'h8000_0000, 32'h40_0000, 32'h40_0000, 32'h0, 32'hFFFF_FFFF, 24'h7, 24'h8};
        rows.insert(rows.size(), row);
        row.it = '{32'hFFFF_FFFF, 32'h1_0000, 32'h2_0000, 32'h100_0000, 32'h0, 24'h9, 24'hA};
        rows.insert(rows.size(), row);
        foreach (rows[i]) send_pair(rows[i].it, rows[i].typed, rows[i].res);
        i_s_axis_tvalid <= 1'b0;
        drain_links();

        // Zero mu, zero node count, unknown index, low and high exponents
        write_reg(hpl_pkg::CFG_MU_SCALE, 32'd0);
        write_reg(CFG_UNKNOWN, 32'hDEAD_BEEF);
        for (int i = 0; i < 4; i++) send_pair(rand_pair(), 1'b0, '0);
        i_s_axis_tvalid <= 1'b0;
        drain_links();
        write_reg(hpl_pkg::CFG_MU_SCALE, 32'hFFFF_FFFF);
        write_reg(hpl_pkg::CFG_NODE_COUNT, 32'd0);
        for (int i = 0; i < 4; i++) send_pair(rand_pair(), 1'b0, '0);
        i_s_axis_tvalid <= 1'b0;
        drain_links();
        write_reg(hpl_pkg::CFG_NODE_COUNT, 32'(hpl_pkg::NODE_COUNT_RST));
        write_reg(hpl_pkg::CFG_INV_TEMP, 32'd0);
        for (int i = 0; i < 4; i++) send_pair(rand_pair(), 1'b0, '0);
        i_s_axis_tvalid <= 1'b0;
        drain_links();

        // Random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(hpl_pkg::CFG_NODE_COUNT, 32'd2);
                    write_reg(hpl_pkg::CFG_MU_SCALE, 32'd1);
                    write_reg(hpl_pkg::CFG_INV_TEMP, 32'h100_0000);
                end
                1: begin
                    write_reg(hpl_pkg::CFG_NODE_COUNT, 32'h100_0000);
                    write_reg(hpl_pkg::CFG_MU_SCALE, 32'hFFFF_FFFF);
                    write_reg(hpl_pkg::CFG_INV_TEMP, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(hpl_pkg::CFG_NODE_COUNT, 32'h1FF_FFFF);
                    write_reg(hpl_pkg::CFG_MU_SCALE, hpl_pkg::MU_SCALE_RST);
                    write_reg(hpl_pkg::CFG_INV_TEMP, hpl_pkg::INV_TEMP_RST);
                end
                default: begin
                    write_reg(hpl_pkg::CFG_NODE_COUNT, $urandom_range(2, 32'h100_0000));
                    write_reg(hpl_pkg::CFG_MU_SCALE, $urandom_range(1, 32'h1000_0000));
                    write_reg(hpl_pkg::CFG_INV_TEMP, $urandom_range(32'h100_0000, 32'h600_0000));
                end
            endcase
            if (ph == 3) hold_len = 400;
            for (int i = 0; i < 100; i++) send_pair(rand_pair(), 1'b0, '0);
            i_s_axis_tvalid <= 1'b0;
            drain_links();
        end

        if (errors == 0) begin
            $display("hyperbolic_pair_link_decision verification clean");
        end else begin
            $display("hyperbolic_pair_link_decision verification failed");
        end
        $finish;
    end

endmodule
